>>> hw/rtl/xed_pkg.sv
// ----------------------------------------------------------------------------
// xed_pkg - shared types and constants for the XML entity decoder
// Sequencer states, emit request bundle, output stage status and byte helpers.
// ----------------------------------------------------------------------------
package xed_pkg;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PROC,
		ST_SKIP,
		ST_WS,
		ST_SIGN,
		ST_PFX,
		ST_PX,
		ST_DIG,
		ST_CODE,
		ST_DROP,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic       push;
		logic       flush;
		logic       last;
		logic [7:0] data;
	} emit_t;

	typedef struct packed {
		logic push_ok;
		logic flush_done;
	} oq_stat_t;

	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_QUOT  = 8'h22;
	localparam logic [7:0] CH_APOS  = 8'h27;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_LX    = 8'h78;
	localparam logic [7:0] CH_UX    = 8'h58;
	localparam logic [7:0] CH_A     = 8'h61;
	localparam logic [7:0] CH_M     = 8'h6D;
	localparam logic [7:0] CH_P     = 8'h70;
	localparam logic [7:0] CH_L     = 8'h6C;
	localparam logic [7:0] CH_G     = 8'h67;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_Q     = 8'h71;
	localparam logic [7:0] CH_U     = 8'h75;
	localparam logic [7:0] CH_O     = 8'h6F;
	localparam logic [7:0] CH_S     = 8'h73;

	localparam logic [4:0] DIGIT_NONE = 5'h1F;

	localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
	localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
	localparam logic [1:0] UTF8_CONT  = 2'b10;

	function automatic logic [4:0] digit_val(input logic [7:0] c);
		logic [4:0] d;
		begin
			if (c >= 8'h30 && c <= 8'h39) begin
				d = 5'(c - 8'h30);
			end else if (c >= 8'h61 && c <= 8'h66) begin
				d = 5'(c - 8'h57);
			end else if (c >= 8'h41 && c <= 8'h46) begin
				d = 5'(c - 8'h37);
			end else begin
				d = DIGIT_NONE;
			end
			return d;
		end
	endfunction

	function automatic logic is_ws(input logic [7:0] c);
		return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
	endfunction

endpackage

>>> hw/rtl/xed_if.sv
// ----------------------------------------------------------------------------
// xed_if - stream channels of the XML entity decoder
// Input byte channel and output byte channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface xed_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface xed_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_last;

	modport source (output valid, output out_byte, output out_last, input ready);
	modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

>>> hw/rtl/xed_acc.sv
// ----------------------------------------------------------------------------
// xed_acc - numeric accumulator
// Shared multiply-add unit: acc = acc * base + digit, one digit a cycle while
// step is high, with sticky 64-bit overflow.
// ----------------------------------------------------------------------------
module xed_acc (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        clear,
	input  logic        step,
	input  logic        hex,
	input  logic [3:0]  digit,
	output logic [31:0] val,
	output logic        ovf
);

	logic [63:0] acc_q;
	logic        ovf_q;
	logic [67:0] prod;

	always_comb begin
		if (hex) begin
			prod = {acc_q, 4'b0000} + 68'(digit);
		end else begin
			prod = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + 68'(digit);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			ovf_q <= 1'b0;
		end else if (clear) begin
			acc_q <= '0;
			ovf_q <= 1'b0;
		end else if (step && !ovf_q) begin
			if (prod[67:64] != 4'd0) begin
				ovf_q <= 1'b1;
			end else begin
				acc_q <= prod[63:0];
			end
		end
	end

	assign val = ovf_q ? 32'hFFFF_FFFF : acc_q[31:0];
	assign ovf = ovf_q;

endmodule

>>> hw/rtl/xed_outq.sv
// ----------------------------------------------------------------------------
// xed_outq - output staging
// One pending word held back until the next word or the end of the string
// decides its last flag, then an output register toward the sink.
// ----------------------------------------------------------------------------
module xed_outq (
	input  logic              clk,
	input  logic              arst_n,
	input  xed_pkg::emit_t    em,
	output xed_pkg::oq_stat_t stat,
	xed_out_if.source         tx
);

	logic       pend_v_q;
	logic [7:0] pend_q;
	logic       out_v_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;
	logic       out_free;
	logic       mv;
	logic       push_go;

	assign out_free = !out_v_q || tx.ready;
	assign stat.push_ok = !pend_v_q || out_free;
	assign stat.flush_done = !pend_v_q || out_free;
	assign push_go = em.push && stat.push_ok;
	assign mv = pend_v_q && out_free && (em.push || em.flush);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (push_go) begin
				pend_v_q <= 1'b1;
			end else if (mv) begin
				pend_v_q <= 1'b0;
			end
			if (mv) begin
				out_v_q <= 1'b1;
			end else if (tx.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_go) begin
			pend_q <= em.data;
		end
		if (mv) begin
			out_byte_q <= pend_q;
			out_last_q <= em.push ? 1'b0 : em.last;
		end
	end

	assign tx.valid    = out_v_q;
	assign tx.out_byte = out_byte_q;
	assign tx.out_last = out_last_q;

endmodule

>>> hw/rtl/xml_entity_decoder.sv
// ----------------------------------------------------------------------------
// xml_entity_decoder - XML character entity decoder
// Byte stream in, byte stream out with named and numeric entities decoded.
// ----------------------------------------------------------------------------
//  channel | dir | word               | accepted when
//  rx      | in  | in_byte, in_last   | rx.valid && rx.ready
//
//  tx      | out | out_byte, out_last | tx.valid && tx.ready
//
// One sequencer walks a shift buffer of ENTITY_REACH+1 bytes, one byte a cycle
// while a stalled tx does not hold it. A plain byte goes through accept, pass,
// end check and flush; a closing ';' adds a parse and a drop step per held byte
// plus up to three output bytes. A failed entity emits '&' and rescans its held
// bytes; a run of '&' can fail on every rescan.
// Reset clears counts and state; buffer contents are left as they are.
// A stalled tx holds the sequencer only when it must emit a word.
// ----------------------------------------------------------------------------
module xml_entity_decoder #(
	parameter int ENTITY_REACH = 12
) (
	input  logic      clk,
	input  logic      arst_n,
	xed_in_if.sink    rx,
	xed_out_if.source tx
);

	localparam int DEPTH = ENTITY_REACH + 1;
	localparam int IW    = $clog2(DEPTH);
	localparam int CW    = $clog2(ENTITY_REACH + 2);

	xed_pkg::state_t   st_q, st_d;
	xed_pkg::emit_t    em;
	xed_pkg::oq_stat_t oq;

	logic [7:0]    hold_q [DEPTH];
	logic [CW-1:0] hc_q, hc_d;
	logic [CW-1:0] tot_q, tot_d;
	logic [CW-1:0] rem_q, rem_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [1:0]    idx_q, idx_d;
	logic          last_q, last_d;
	logic          hex_q, hex_d;
	logic          neg_q, neg_d;
	logic          shift;
	logic          accept;
	logic          acc_clr, acc_step;
	logic [31:0]   acc_val;
	logic          acc_ovf;
	logic [31:0]   cp;
	logic [1:0]    nb;
	logic [7:0]    code_byte;
	logic [7:0]    cur;
	logic [4:0]    dig;
	logic          dig_ok;
	logic          m_amp, m_lt, m_gt, m_quot, m_apos, m_named, numeric, hexsel;
	logic [7:0]    named_char;

	assign accept   = rx.valid && rx.ready;
	assign rx.ready = (st_q == xed_pkg::ST_IDLE);
	assign cur      = hold_q[hc_q[IW-1:0]];

	// name compares at fixed positions after the '&'
	assign m_amp  = (hc_q == CW'(4)) && hold_q[1] == xed_pkg::CH_A && hold_q[2] == xed_pkg::CH_M
		&& hold_q[3] == xed_pkg::CH_P;
	assign m_lt   = (hc_q == CW'(3)) && hold_q[1] == xed_pkg::CH_L && hold_q[2] == xed_pkg::CH_T;
	assign m_gt   = (hc_q == CW'(3)) && hold_q[1] == xed_pkg::CH_G && hold_q[2] == xed_pkg::CH_T;
	assign m_quot = (hc_q == CW'(5)) && hold_q[1] == xed_pkg::CH_Q && hold_q[2] == xed_pkg::CH_U
		&& hold_q[3] == xed_pkg::CH_O && hold_q[4] == xed_pkg::CH_T;
	assign m_apos = (hc_q == CW'(5)) && hold_q[1] == xed_pkg::CH_A && hold_q[2] == xed_pkg::CH_P
		&& hold_q[3] == xed_pkg::CH_O && hold_q[4] == xed_pkg::CH_S;
	assign m_named = m_amp || m_lt || m_gt || m_quot || m_apos;
	assign numeric = (hc_q > CW'(2)) && hold_q[1] == xed_pkg::CH_HASH;
	assign hexsel  = hold_q[2] == xed_pkg::CH_LX || hold_q[2] == xed_pkg::CH_UX;

	always_comb begin
		if (m_amp) begin
			named_char = xed_pkg::CH_AMP;
		end else if (m_lt) begin
			named_char = xed_pkg::CH_LT;
		end else if (m_gt) begin
			named_char = xed_pkg::CH_GT;
		end else if (m_quot) begin
			named_char = xed_pkg::CH_QUOT;
		end else begin
			named_char = xed_pkg::CH_APOS;
		end
	end

	assign dig    = xed_pkg::digit_val(hold_q[0]);
	assign dig_ok = hex_q ? (dig != xed_pkg::DIGIT_NONE) : (dig < 5'd10);

	xed_acc u_acc (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (acc_clr),
		.step   (acc_step),
		.hex    (hex_q),
		.digit  (dig[3:0]),
		.val    (acc_val),
		.ovf    (acc_ovf)
	);

	// code point to UTF-8 style bytes
	assign cp = (neg_q && !acc_ovf) ? (32'd0 - acc_val) : acc_val;

	always_comb begin
		code_byte = cp[7:0];
		if (cp < 32'h100) begin
			nb = 2'd1;
		end else if (cp < 32'h800) begin
			nb = 2'd2;
			if (idx_q == 2'd0) begin
				code_byte = xed_pkg::UTF8_LEAD2 | {3'b000, cp[10:6]};
			end else begin
				code_byte = {xed_pkg::UTF8_CONT, cp[5:0]};
			end
		end else begin
			nb = 2'd3;
			if (idx_q == 2'd0) begin
				code_byte = xed_pkg::UTF8_LEAD3 | cp[19:12];
			end else if (idx_q == 2'd1) begin
				code_byte = {xed_pkg::UTF8_CONT, cp[11:6]};
			end else begin
				code_byte = {xed_pkg::UTF8_CONT, cp[5:0]};
			end
		end
	end

	always_comb begin
		st_d     = st_q;
		hc_d     = hc_q;
		rem_d    = rem_q;
		cnt_d    = cnt_q;
		idx_d    = idx_q;
		last_d   = last_q;
		hex_d    = hex_q;
		neg_d    = neg_q;
		shift    = 1'b0;
		acc_clr  = 1'b0;
		acc_step = 1'b0;
		em       = '0;
		case (st_q)
			xed_pkg::ST_IDLE: begin
				if (accept) begin
					last_d = rx.in_last;
					st_d   = xed_pkg::ST_PROC;
				end
			end
			xed_pkg::ST_PROC: begin
				if (hc_q < tot_q) begin
					if (hc_q == '0) begin
						if (cur == xed_pkg::CH_AMP) begin
							hc_d = CW'(1);
						end else begin
							em.push = 1'b1;
							em.data = cur;
							shift   = oq.push_ok;
						end
					end else if (cur == xed_pkg::CH_SEMI && m_named) begin
						em.push = 1'b1;
						em.data = named_char;
						if (oq.push_ok) begin
							hc_d  = '0;
							cnt_d = hc_q + CW'(1);
							st_d  = xed_pkg::ST_DROP;
						end
					end else if (cur == xed_pkg::CH_SEMI && numeric) begin
						hc_d    = '0;
						hex_d   = hexsel;
						neg_d   = 1'b0;
						acc_clr = 1'b1;
						cnt_d   = hexsel ? CW'(3) : CW'(2);
						rem_d   = hc_q - (hexsel ? CW'(3) : CW'(2));
						st_d    = xed_pkg::ST_SKIP;
					end else if (cur != xed_pkg::CH_SEMI && hc_q < CW'(ENTITY_REACH)) begin
						hc_d = hc_q + CW'(1);
					end else begin
						// give up: emit '&' and rescan what was held
						em.push = 1'b1;
						em.data = xed_pkg::CH_AMP;
						if (oq.push_ok) begin
							shift = 1'b1;
							hc_d  = '0;
						end
					end
				end else if (last_q && hc_q != '0) begin
					em.push = 1'b1;
					em.data = xed_pkg::CH_AMP;
					if (oq.push_ok) begin
						shift = 1'b1;
						hc_d  = '0;
					end
				end else begin
					st_d = xed_pkg::ST_FLUSH;
				end
			end
			xed_pkg::ST_SKIP: begin
				shift = 1'b1;
				cnt_d = cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					st_d = xed_pkg::ST_WS;
				end
			end
			xed_pkg::ST_WS: begin
				if (rem_q != '0 && xed_pkg::is_ws(hold_q[0])) begin
					shift = 1'b1;
					rem_d = rem_q - CW'(1);
				end else begin
					st_d = xed_pkg::ST_SIGN;
				end
			end
			xed_pkg::ST_SIGN: begin
				if (rem_q != '0 && (hold_q[0] == xed_pkg::CH_PLUS
						|| hold_q[0] == xed_pkg::CH_MINUS)) begin
					neg_d = hold_q[0] == xed_pkg::CH_MINUS;
					shift = 1'b1;
					rem_d = rem_q - CW'(1);
				end
				st_d = xed_pkg::ST_PFX;
			end
			xed_pkg::ST_PFX: begin
				if (hex_q && rem_q > CW'(2) && hold_q[0] == xed_pkg::CH_ZERO
						&& (hold_q[1] == xed_pkg::CH_LX || hold_q[1] == xed_pkg::CH_UX)
						&& xed_pkg::digit_val(hold_q[2]) != xed_pkg::DIGIT_NONE) begin
					shift = 1'b1;
					rem_d = rem_q - CW'(1);
					st_d  = xed_pkg::ST_PX;
				end else begin
					st_d = xed_pkg::ST_DIG;
				end
			end
			xed_pkg::ST_PX: begin
				shift = 1'b1;
				rem_d = rem_q - CW'(1);
				st_d  = xed_pkg::ST_DIG;
			end
			xed_pkg::ST_DIG: begin
				if (rem_q != '0 && dig_ok) begin
					acc_step = 1'b1;
					shift    = 1'b1;
					rem_d    = rem_q - CW'(1);
				end else begin
					cnt_d = rem_q + CW'(1);
					idx_d = 2'd0;
					st_d  = xed_pkg::ST_CODE;
				end
			end
			xed_pkg::ST_CODE: begin
				em.push = 1'b1;
				em.data = code_byte;
				if (oq.push_ok) begin
					if (idx_q == nb - 2'd1) begin
						st_d = xed_pkg::ST_DROP;
					end else begin
						idx_d = idx_q + 2'd1;
					end
				end
			end
			xed_pkg::ST_DROP: begin
				shift = 1'b1;
				cnt_d = cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					st_d = xed_pkg::ST_PROC;
				end
			end
			xed_pkg::ST_FLUSH: begin
				em.flush = 1'b1;
				em.last  = last_q;
				if (oq.flush_done) begin
					st_d = xed_pkg::ST_IDLE;
				end
			end
			default: begin
				st_d = xed_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		tot_d = tot_q;
		if (accept) begin
			tot_d = tot_q + CW'(1);
		end else if (shift) begin
			tot_d = tot_q - CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= xed_pkg::ST_IDLE;
			hc_q   <= '0;
			tot_q  <= '0;
			rem_q  <= '0;
			cnt_q  <= '0;
			idx_q  <= '0;
			last_q <= 1'b0;
			hex_q  <= 1'b0;
			neg_q  <= 1'b0;
		end else begin
			st_q   <= st_d;
			hc_q   <= hc_d;
			tot_q  <= tot_d;
			rem_q  <= rem_d;
			cnt_q  <= cnt_d;
			idx_q  <= idx_d;
			last_q <= last_d;
			hex_q  <= hex_d;
			neg_q  <= neg_d;
		end
	end

	// held bytes first, pending rescan bytes behind them
	always_ff @(posedge clk) begin
		if (accept) begin
			hold_q[tot_q[IW-1:0]] <= rx.in_byte;
		end else if (shift) begin
			for (int i = 0; i < DEPTH - 1; i++) begin
				hold_q[i] <= hold_q[i+1];
			end
		end
	end

	xed_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.em     (em),
		.stat   (oq),
		.tx     (tx)
	);

endmodule

>>> hw/rtl/xed_chk.sv
// ----------------------------------------------------------------------------
// xed_chk - port checker for the XML entity decoder
// Watches both channels and is bound to the top level.
// ----------------------------------------------------------------------------
module xed_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       rx_valid,
	input logic       rx_ready,
	input logic       tx_valid,
	input logic       tx_ready,
	input logic [7:0] tx_byte,
	input logic       tx_last
);

	// a stalled output word holds
	a_tx_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && !tx_ready |=> tx_valid && $stable(tx_byte) && $stable(tx_last))
		else $error("tx word changed while stalled");

	// one byte at a time: busy right after an accept
	a_rx_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rx_valid && rx_ready |=> !rx_ready)
		else $error("input taken while busy");

	// tx_valid and a valid word are always known
	a_tx_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown(tx_valid) && (!tx_valid || !$isunknown({tx_byte, tx_last})))
		else $error("unknown value on tx");

endmodule

bind xml_entity_decoder xed_chk u_xed_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.rx_valid (rx.valid),
	.rx_ready (rx.ready),
	.tx_valid (tx.valid),
	.tx_ready (tx.ready),
	.tx_byte  (tx.out_byte),
	.tx_last  (tx.out_last)
);
